// ===== hw/rtl/fcpp_pkg.sv =====
// Shared types and constants for the framed command packet parser.
`timescale 1ns / 1ps
`default_nettype none

package fcpp_pkg;

  // Width of the configuration register index
  localparam int unsigned CfgIdxW = 2;
  // Width of the configuration write data
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxBodyLen   = 2'd0,
    CfgIdleTimeout  = 2'd1
  } cfg_idx_e;

  // Item kinds on the request channel
  typedef enum logic [1:0] {
    CmdByte     = 2'd0,
    CmdTick     = 2'd1,
    CmdLinkLost = 2'd2
  } cmd_e;

  // Parser phases, one-hot
  typedef enum logic [3:0] {
    PhWaitFf   = 4'b0001,
    PhWait55   = 4'b0010,
    PhWaitLen  = 4'b0100,
    PhBody     = 4'b1000
  } phase_e;

  // Framing bytes and body positions
  localparam logic [7:0] PreambleA     = 8'hFF;
  localparam logic [7:0] PreambleB     = 8'h55;
  localparam logic [7:0] TriggerByte   = 8'hC8;
  localparam logic [7:0] PosAction     = 8'd6;
  localparam logic [7:0] PosDevice     = 8'd7;
  localparam logic [7:0] PosMovement   = 8'd9;
  localparam logic [7:0] ActionRun     = 8'd1;
  localparam logic [7:0] ActionStandby = 8'd3;

  // Register reset values
  localparam logic [7:0]  MaxBodyLenRst  = 8'd64;
  localparam logic [15:0] IdleTimeoutRst = 16'd3000;

  // One incoming request
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } fcpp_in_t;

  // One result
  typedef struct packed {
    logic [7:0] action;
    logic [7:0] device;
    logic [7:0] movement;
    logic       synthesized;
  } fcpp_out_t;

  // Handover from the input stage to the core
  typedef struct packed {
    logic     valid;
    fcpp_in_t item;
  } fcpp_item_t;

  // Handover from the core to the result stage
  typedef struct packed {
    logic      load;
    fcpp_out_t result;
  } fcpp_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcpp_in_stage.sv =====
// Input register stage: holds one accepted request until the core consumes it.
`timescale 1ns / 1ps
`default_nettype none

module fcpp_in_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire fcpp_pkg::fcpp_in_t  in_data_i,
  input  wire logic                advance_i,
  output fcpp_pkg::fcpp_item_t     item_o
);
  import fcpp_pkg::*;

  logic     valid_d, valid_q;
  fcpp_in_t item_q;
  logic     accept;

  // The stage stalls only when its held request cannot move on this cycle.
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.item  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fcpp_core.sv =====
// Parser state, trigger and idle timer, configuration registers and result logic.
`timescale 1ns / 1ps
`default_nettype none

module fcpp_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [fcpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [fcpp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire fcpp_pkg::fcpp_item_t          item_i,
  input  wire logic                          out_free_i,
  output logic                               advance_o,
  output fcpp_pkg::fcpp_res_t                res_o
);
  import fcpp_pkg::*;

  phase_e      phase_d, phase_q;
  logic [7:0]  len_d, len_q;
  logic [7:0]  pos_d, pos_q;
  logic [7:0]  act_d, act_q;
  logic [7:0]  dev_d, dev_q;
  logic [7:0]  mov_d, mov_q;
  logic        armed_d, armed_q;
  logic [15:0] idle_d, idle_q;
  logic [7:0]  max_len_q;
  logic [15:0] timeout_q;
  logic        emit;
  fcpp_out_t   result;
  logic [7:0]  b;
  logic [7:0]  res_act;

  assign b = item_i.item.data_byte;

  // Next state and result for the request held in the input stage.
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    act_d   = act_q;
    dev_d   = dev_q;
    mov_d   = mov_q;
    armed_d = armed_q;
    idle_d  = idle_q;
    emit    = 1'b0;
    res_act = '0;
    result  = '0;
    unique case (item_i.item.command)
      CmdByte: begin
        idle_d  = '0;
        armed_d = (b == TriggerByte);
        unique case (phase_q)
          PhWaitFf: begin
            if (b == PreambleA) begin
              phase_d = PhWait55;
            end
          end
          PhWait55: begin
            if (b == PreambleB) begin
              phase_d = PhWaitLen;
            end else if (b != PreambleA) begin
              phase_d = PhWaitFf;
            end
          end
          PhWaitLen: begin
            pos_d = '0;
            if (b == '0 || b > max_len_q) begin
              phase_d = PhWaitFf;
              len_d   = '0;
            end else begin
              phase_d = PhBody;
              len_d   = b;
            end
          end
          PhBody: begin
            if (pos_q == PosAction) begin
              act_d = b;
            end
            if (pos_q == PosDevice) begin
              dev_d = b;
            end
            if (pos_q == PosMovement) begin
              mov_d = b;
            end
            pos_d = pos_q + 8'd1;
            // The last body byte closes the packet and yields a result.
            if (pos_d >= len_q) begin
              phase_d            = PhWaitFf;
              emit               = 1'b1;
              res_act            = (pos_d > PosAction) ? act_d : '0;
              result.action      = res_act;
              result.device      = (pos_d > PosDevice) ? dev_d : '0;
              result.movement    = (res_act == ActionRun && pos_d > PosMovement) ?
                                   mov_d : '0;
              result.synthesized = 1'b0;
            end
          end
          default: begin
            phase_d = PhWaitFf;
          end
        endcase
      end
      CmdTick: begin
        if (armed_q && idle_q >= timeout_q) begin
          emit = 1'b1;
        end else if (idle_q != '1) begin
          idle_d = idle_q + 16'd1;
        end
      end
      CmdLinkLost: begin
        emit = 1'b1;
      end
      default: begin
      end
    endcase
    // Synthesized standby resets the parser, trigger and idle timer.
    if (emit && item_i.item.command != CmdByte) begin
      phase_d            = PhWaitFf;
      len_d              = '0;
      pos_d              = '0;
      armed_d            = 1'b0;
      idle_d             = '0;
      result.action      = ActionStandby;
      result.device      = '0;
      result.movement    = '0;
      result.synthesized = 1'b1;
    end
  end

  // A request moves on unless its result finds the result stage occupied.
  assign advance_o    = item_i.valid & (~emit | out_free_i);
  assign res_o.load   = advance_o & emit;
  assign res_o.result = result;

  // Parser and timer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWaitFf;
      len_q   <= '0;
      pos_q   <= '0;
      act_q   <= '0;
      dev_q   <= '0;
      mov_q   <= '0;
      armed_q <= 1'b0;
      idle_q  <= '0;
    end else if (advance_o) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      act_q   <= act_d;
      dev_q   <= dev_d;
      mov_q   <= mov_d;
      armed_q <= armed_d;
      idle_q  <= idle_d;
    end
  end

  // Configuration registers; indexes outside the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxBodyLenRst;
      timeout_q <= IdleTimeoutRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMaxBodyLen) begin
        max_len_q <= cfg_wdata_i[7:0];
      end
      if (cfg_index_i == CfgIdleTimeout) begin
        timeout_q <= cfg_wdata_i[15:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcpp_out_stage.sv =====
// Result register: holds one result until the downstream side takes it.
`timescale 1ns / 1ps
`default_nettype none

module fcpp_out_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fcpp_pkg::fcpp_res_t  res_i,
  output logic                      out_free_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output fcpp_pkg::fcpp_out_t       out_data_o
);
  import fcpp_pkg::*;

  logic      valid_d, valid_q;
  fcpp_out_t data_q;

  // The register can take a new result when empty or being emptied now.
  assign out_free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.load) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (res_i.load) begin
      data_q <= res_i.result;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/framed_command_packet_parser.sv =====
// Top level of the framed command packet parser.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock unless stalled: a stream byte, a one-millisecond tick or a
// link-lost event. Every request is held in an input register, processed
// combinationally against the parser state, and any result is written to a
// result register, so a result passes through the input register and the
// result register before it is presented and can be taken at the following edge;
// the sustained rate is one request per cycle while the output is not stalled. The input side
// stalls only while the result register is full and stalled and the held
// request would produce a result; that stall follows out_stall_i in the same
// cycle. Packets start with FF 55 (repeated FF bytes allowed), then a length
// byte (zero or above max_body_len drops the packet) and the body; body bytes
// 6, 7 and 9 give action, device and movement. A C8 byte arms the standby
// trigger; an armed trigger after idle_timeout_ticks quiet ticks, or a link
// loss, yields a synthesized standby (action 3) and resets the parser.
// Configuration writes are always ready and take effect on the next cycle;
// they should be made while no request is in flight.
module framed_command_packet_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire fcpp_pkg::fcpp_in_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output fcpp_pkg::fcpp_out_t                out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fcpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [fcpp_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import fcpp_pkg::*;

  fcpp_item_t item;
  fcpp_res_t  res;
  logic       advance;
  logic       out_free;

  assign cfg_ready_o = 1'b1;

  // Input register.
  fcpp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  // Parser and timer.
  fcpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_o       (res)
  );

  // Result register.
  fcpp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fcpp_checker.sv =====
// Port-level checks for the framed command packet parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fcpp_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_o,
  input  wire fcpp_pkg::fcpp_in_t            in_data_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  input  wire fcpp_pkg::fcpp_out_t           out_data_o
);
  import fcpp_pkg::*;

  // A stalled request keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The input side stalls only behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A synthesized standby carries action 3 and nothing else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.synthesized |->
      out_data_o.action == ActionStandby && out_data_o.device == '0 &&
      out_data_o.movement == '0)
    else $error("malformed synthesized standby");

  // Movement is only reported for the run action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ActionRun |-> out_data_o.movement == '0)
    else $error("movement reported without run action");

endmodule

bind framed_command_packet_parser fcpp_checker u_fcpp_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the framed command packet parser.
`timescale 1ns / 1ps

module tb;
  import fcpp_pkg::*;

  localparam int ClkPeriod    = 4;
  localparam int ResetCycles  = 5;
  localparam int SettleCycles = 8;
  localparam int EndCycles    = 20;
  localparam int DrainLimit   = 5000;
  localparam int CycleLimit   = 2_000_000;
  localparam int RandomPhases = 8;
  localparam int PhaseItems   = 75;
  localparam int ReportLimit  = 10;

  // Command code that the block has no use for.
  localparam logic [1:0] CmdUnused = 2'd3;

  typedef enum logic [1:0] {
    StepReq,
    StepDrain,
    StepCfg
  } step_kind_e;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallLong
  } stall_mode_e;

  typedef struct packed {
    step_kind_e kind;
    fcpp_in_t   req;
    cfg_idx_e   reg_idx;
    logic [15:0] wdata;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  fcpp_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  fcpp_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_e    cfg_index = CfgMaxBodyLen;
  logic [15:0] cfg_wdata = '0;

  step_t     stim_q[$];
  fcpp_out_t awaited[$];

  // Mirror of the parser state and its registers.
  logic [7:0]  cfg_max_len;
  logic [15:0] cfg_timeout;
  phase_e      pp_phase;
  logic [7:0]  pp_body_len;
  logic [7:0]  pp_body_pos;
  logic [7:0]  pp_action;
  logic [7:0]  pp_device;
  logic [7:0]  pp_movement;
  logic        pp_armed;
  logic [15:0] pp_quiet_ticks;

  int outstanding = 0;
  int quiet_cycles = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int burst_left = 1;
  int n_pushed = 0;
  int n_accepted = 0;
  int n_packets = 0;
  int n_standbys = 0;
  int n_cfg_writes = 0;
  int n_mismatch = 0;
  int n_missing = 0;
  bit mix_ticks = 1'b0;
  stall_mode_e stall_mode = StallNone;
  int stall_mode_left = 0;
  int stall_run = 0;

  framed_command_packet_parser u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Standby clears the parser, the trigger and the quiet time.
  function automatic void push_standby();
    fcpp_out_t res;
    pp_phase       = PhWaitFf;
    pp_body_len    = '0;
    pp_body_pos    = '0;
    pp_armed       = 1'b0;
    pp_quiet_ticks = '0;
    res.action      = ActionStandby;
    res.device      = '0;
    res.movement    = '0;
    res.synthesized = 1'b1;
    awaited.push_back(res);
  endfunction

  // Advances the mirrored parser by one accepted request.
  function automatic void parse_request(input fcpp_in_t req);
    fcpp_out_t  res;
    logic [7:0] b;
    b = req.data_byte;
    case (req.command)
      CmdByte: begin
        pp_quiet_ticks = '0;
        pp_armed = (b == TriggerByte);
        case (pp_phase)
          PhWaitFf: begin
            if (b == PreambleA) pp_phase = PhWait55;
          end
          PhWait55: begin
            if (b == PreambleB) pp_phase = PhWaitLen;
            else if (b != PreambleA) pp_phase = PhWaitFf;
          end
          PhWaitLen: begin
            pp_body_len = b;
            pp_body_pos = '0;
            if (b == 8'd0 || b > cfg_max_len) begin
              pp_phase    = PhWaitFf;
              pp_body_len = '0;
            end else begin
              pp_phase = PhBody;
            end
          end
          default: begin
            if (pp_body_pos == PosAction) pp_action = b;
            if (pp_body_pos == PosDevice) pp_device = b;
            if (pp_body_pos == PosMovement) pp_movement = b;
            pp_body_pos = pp_body_pos + 8'd1;
            if (pp_body_pos >= pp_body_len) begin
              pp_phase = PhWaitFf;
              res.action = (pp_body_pos > PosAction) ? pp_action : 8'd0;
              res.device = (pp_body_pos > PosDevice) ? pp_device : 8'd0;
              res.movement = (res.action == ActionRun && pp_body_pos > PosMovement) ?
                             pp_movement : 8'd0;
              res.synthesized = 1'b0;
              awaited.push_back(res);
            end
          end
        endcase
      end
      CmdTick: begin
        if (pp_armed && pp_quiet_ticks >= cfg_timeout) push_standby();
        else if (pp_quiet_ticks != 16'hFFFF) pp_quiet_ticks = pp_quiet_ticks + 16'd1;
      end
      CmdLinkLost: push_standby();
      default: ;
    endcase
  endfunction

  // Request driver: bursts of requests with random gaps, register writes only when idle.
  always @(posedge clk or negedge rst_n) begin : drive_proc
    step_t head;
    logic  nxt_valid;
    logic  nxt_cfg;
    logic  idle_now;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= CfgMaxBodyLen;
      cfg_wdata <= '0;
    end else begin
      idle_now  = (outstanding == 0) && (quiet_cycles >= SettleCycles) && !in_valid;
      nxt_valid = in_valid && in_stall;
      nxt_cfg   = cfg_valid && !cfg_ready;
      if (!nxt_valid && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          head = stim_q[0];
          case (head.kind)
            StepReq: begin
              head = stim_q.pop_front();
              in_data   <= head.req;
              nxt_valid = 1'b1;
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                             $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
            StepDrain: begin
              if (idle_now) head = stim_q.pop_front();
            end
            default: begin
              if (idle_now) begin
                head = stim_q.pop_front();
                cfg_index <= head.reg_idx;
                cfg_wdata <= head.wdata;
                nxt_cfg   = 1'b1;
              end
            end
          endcase
        end
      end
      in_valid  <= nxt_valid;
      cfg_valid <= nxt_cfg;
    end
  end

  // Result stall pattern, in one of four randomly chosen modes.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = stall_mode_e'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(20, 200);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        StallNone:     out_stall <= 1'b0;
        StallRandom:   out_stall <= ($urandom_range(0, 1) == 1);
        StallPeriodic: out_stall <= (cycle_cnt % 3 == 0);
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_run = $urandom_range(4, 20);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // Result checker, register mirror and prediction of accepted requests.
  always @(posedge clk or negedge rst_n) begin : check_proc
    fcpp_out_t want;
    if (!rst_n) begin
      cfg_max_len    = MaxBodyLenRst;
      cfg_timeout    = IdleTimeoutRst;
      pp_phase       = PhWaitFf;
      pp_body_len    = '0;
      pp_body_pos    = '0;
      pp_action      = '0;
      pp_device      = '0;
      pp_movement    = '0;
      pp_armed       = 1'b0;
      pp_quiet_ticks = '0;
      quiet_cycles  <= 0;
      outstanding   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= ReportLimit)
            $display("Unexpected result: action=%02h device=%02h movement=%02h synth=%0b",
                     out_data.action, out_data.device, out_data.movement,
                     out_data.synthesized);
        end else begin
          want = awaited.pop_front();
          if (want.synthesized) n_standbys++;
          else n_packets++;
          if (out_data.action !== want.action || out_data.device !== want.device ||
              out_data.movement !== want.movement ||
              out_data.synthesized !== want.synthesized) begin
            n_mismatch++;
            if (n_mismatch <= ReportLimit)
              $display("Mismatch at cycle %0d: expected %02h/%02h/%02h/%0b, got %02h/%02h/%02h/%0b",
                       cycle_cnt, want.action, want.device, want.movement, want.synthesized,
                       out_data.action, out_data.device, out_data.movement,
                       out_data.synthesized);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg_writes++;
        case (cfg_index)
          CfgMaxBodyLen:  cfg_max_len = cfg_wdata[7:0];
          CfgIdleTimeout: cfg_timeout = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n_accepted++;
        parse_request(in_data);
      end
      quiet_cycles <= (in_valid && !in_stall) ? 0 :
                      (quiet_cycles < SettleCycles ? quiet_cycles + 1 : quiet_cycles);
      outstanding  <= awaited.size();
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt,
               outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic [1:0] cmd, input logic [7:0] b);
    step_t s;
    s.kind         = StepReq;
    s.req.command   = cmd;
    s.req.data_byte = b;
    s.reg_idx      = CfgMaxBodyLen;
    s.wdata        = '0;
    stim_q.push_back(s);
    if (cmd != CmdUnused) n_pushed++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_req(CmdTick, 8'($urandom_range(0, 255)));
  endtask

  // A stream byte, sometimes with ticks slipped in ahead of it.
  task automatic push_byte(input logic [7:0] b);
    if (mix_ticks && $urandom_range(0, 19) == 0) push_ticks($urandom_range(1, 3));
    push_req(CmdByte, b);
  endtask

  task automatic push_frame(input int n_ff, input logic [7:0] len, input int body_n,
                            input logic [7:0] act, input logic [7:0] dev,
                            input logic [7:0] mov);
    logic [7:0] b;
    repeat (n_ff) push_byte(PreambleA);
    push_byte(PreambleB);
    push_byte(len);
    for (int i = 0; i < body_n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == PosAction) b = act;
      else if (i == PosDevice) b = dev;
      else if (i == PosMovement) b = mov;
      push_byte(b);
    end
  endtask

  task automatic push_cfg(input cfg_idx_e idx, input logic [15:0] data);
    step_t s;
    s.kind    = StepCfg;
    s.req     = '0;
    s.reg_idx = idx;
    s.wdata   = data;
    stim_q.push_back(s);
  endtask

  task automatic push_drain();
    step_t s;
    s.kind    = StepDrain;
    s.req     = '0;
    s.reg_idx = CfgMaxBodyLen;
    s.wdata   = '0;
    stim_q.push_back(s);
  endtask

  function automatic logic [7:0] pick_action();
    case ($urandom_range(0, 3))
      0, 1:    return ActionRun;
      2:       return ActionStandby;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_noise();
    case ($urandom_range(0, 3))
      0:       return PreambleA;
      1:       return PreambleB;
      2:       return TriggerByte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random stretch of traffic, shaped by the current register settings.
  task automatic random_episode(input int mx, input int to);
    int sel;
    int len;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      if (mx == 0) len = $urandom_range(1, 12);
      else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, mx);
      else len = $urandom_range(1, (mx < 14) ? mx : 14);
      push_frame($urandom_range(1, 3), 8'(len), len, pick_action(),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else if (sel < 67) begin
      push_byte(TriggerByte);
      if ($urandom_range(0, 3) == 0) push_byte(pick_noise());
      n = to + 3;
      n = (n > 30) ? $urandom_range(0, 30) : $urandom_range(0, n);
      push_ticks(n);
    end else if (sel < 72) begin
      push_req(CmdLinkLost, 8'($urandom_range(0, 255)));
    end else if (sel < 76) begin
      push_req(CmdUnused, 8'($urandom_range(0, 255)));
    end else if (sel < 86) begin
      repeat ($urandom_range(1, 6)) push_byte(pick_noise());
    end else begin
      // Broken frames: bad lengths, a broken preamble, or a body cut by link loss.
      case ($urandom_range(0, 3))
        0: push_frame(1, 8'd0, $urandom_range(0, 3), pick_action(), 8'd0, 8'd0);
        1: begin
          len = (mx < 255) ? $urandom_range(mx + 1, 255) : 0;
          push_frame(1, 8'(len), $urandom_range(0, 4), pick_action(), 8'd0, 8'd0);
        end
        2: begin
          push_byte(PreambleA);
          push_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          push_byte(PreambleA);
          push_byte(PreambleB);
          push_byte(8'($urandom_range(1, 20)));
          repeat ($urandom_range(0, 5)) push_byte(8'($urandom_range(0, 255)));
          push_req(CmdLinkLost, 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin : stimulus_proc
    int gen_max;
    int gen_timeout;
    int target;
    int n;

    // Directed traffic at the reset register values.
    push_req(CmdUnused, PreambleA);
    push_req(CmdLinkLost, 8'h00);
    push_frame(3, 8'd10, 10, ActionRun, 8'hAB, 8'h7E);
    push_frame(1, 8'd7, 7, ActionRun, 8'h11, 8'h22);
    push_frame(1, 8'd1, 1, ActionRun, 8'h00, 8'h00);
    push_frame(2, 8'd8, 8, 8'd2, 8'hFF, 8'h00);
    push_frame(1, 8'd12, 12, 8'd2, 8'h5A, 8'hFF);
    push_frame(1, MaxBodyLenRst, int'(MaxBodyLenRst), ActionRun, 8'h80, 8'h01);
    push_frame(1, MaxBodyLenRst + 8'd1, 4, ActionRun, 8'h00, 8'h00);
    push_frame(1, 8'd0, 0, 8'd0, 8'd0, 8'd0);
    push_byte(PreambleA);
    push_byte(8'h00);
    push_frame(1, 8'd10, 10, ActionRun, 8'h33, TriggerByte);
    push_ticks(6);
    push_ticks(2);
    push_byte(PreambleA);
    push_byte(PreambleB);
    push_byte(8'd5);
    push_byte(8'h01);
    push_req(CmdLinkLost, 8'hFF);
    push_frame(1, 8'd3, 3, 8'd0, 8'd0, 8'd0);
    push_drain();

    // Widest body length and a zero timeout.
    push_cfg(CfgMaxBodyLen, {8'($urandom), 8'd255});
    push_cfg(CfgIdleTimeout, 16'd0);
    push_frame(1, 8'd255, 255, ActionRun, 8'hC3, 8'h3C);
    push_byte(TriggerByte);
    push_ticks(2);
    push_byte(TriggerByte);
    push_req(CmdLinkLost, 8'h00);

    // Zero body length rejects everything; short timeout with disarm and mid-packet trigger.
    push_cfg(CfgMaxBodyLen, 16'd0);
    push_cfg(CfgIdleTimeout, 16'd2);
    push_frame(1, 8'd1, 1, 8'd0, 8'd0, 8'd0);
    push_frame(1, 8'd255, 2, 8'd0, 8'd0, 8'd0);
    push_byte(TriggerByte);
    push_ticks(3);
    push_byte(TriggerByte);
    push_byte(8'h00);
    push_ticks(5);
    push_cfg(CfgMaxBodyLen, 16'd20);
    push_frame(1, 8'd5, 3, 8'd0, 8'd0, 8'd0);
    push_byte(TriggerByte);
    push_ticks(3);
    push_frame(1, 8'd5, 5, 8'd0, 8'd0, 8'd0);

    // Smallest non-zero settings.
    push_cfg(CfgMaxBodyLen, 16'd1);
    push_cfg(CfgIdleTimeout, 16'd1);
    push_frame(1, 8'd1, 1, 8'd0, 8'd0, 8'd0);
    push_frame(1, 8'd2, 2, 8'd0, 8'd0, 8'd0);
    push_byte(TriggerByte);
    push_ticks(2);

    // Longest timeout: a short quiet spell with the trigger armed yields no standby.
    push_cfg(CfgMaxBodyLen, 16'd16);
    push_cfg(CfgIdleTimeout, 16'hFFFF);
    push_frame(1, 8'd16, 16, ActionRun, 8'h42, 8'h24);
    push_byte(TriggerByte);
    push_ticks(20);
    push_frame(1, 8'd10, 10, ActionRun, 8'h01, 8'h99);
    push_drain();

    // Random phases, each under fresh register settings.
    mix_ticks = 1'b1;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      gen_max = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 255) : $urandom_range(6, 20);
      gen_timeout = $urandom_range(0, 12);
      push_cfg(CfgMaxBodyLen, {8'($urandom), 8'(gen_max)});
      push_cfg(CfgIdleTimeout, 16'(gen_timeout));
      target = n_pushed + PhaseItems;
      while (n_pushed < target) begin
        random_episode(gen_max, gen_timeout);
        if ($urandom_range(0, 59) == 0) push_drain();
      end
    end

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last request, then for its results to drain.
    while (stim_q.size() != 0 || in_valid || cfg_valid) @(negedge clk);
    n = 0;
    while (outstanding != 0 && n < DrainLimit) begin
      @(negedge clk);
      n++;
    end
    repeat (EndCycles) @(negedge clk);
    n_missing = awaited.size();
    if (n_missing != 0) $display("%0d expected results never arrived", n_missing);

    $display("Covered %0d requests, %0d parsed packets, %0d synthesized standbys,",
             n_accepted, n_packets, n_standbys);
    $display("and %0d register writes over %0d settings in %0d cycles.",
             n_cfg_writes, RandomPhases + 6, cycle_cnt);
    if (n_mismatch == 0 && n_missing == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
